[hdl/stereo_asymmetric_tanh_saturator_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the stereo saturator.
// Every macro is clocked on clk_i and silent while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef STEREO_ASYMMETRIC_TANH_SATURATOR_DEFINES_SVH
`define STEREO_ASYMMETRIC_TANH_SATURATOR_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define SATS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sats: same-cycle check failed");

// A condition that must hold in the cycle after its trigger.
`define SATS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sats: next-cycle check failed");

`endif

[hdl/sats_pkg.sv]
// ---------------------------------------------------------------------------
// sats_pkg
// Shared types and constants of the stereo tanh saturator.
// ---------------------------------------------------------------------------
package sats_pkg;

  // Default sizes of the block.
  localparam int SAMPLE_WIDTH_DEF     = 24;
  localparam int TANH_TABLE_DEPTH_DEF = 256;

  // Configuration port sizes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Register reset values.
  localparam logic [15:0] DRIVE_RST     = 16'd4096;
  localparam logic [15:0] DRIVE_MIN_RST = 16'd4096;
  localparam logic [15:0] DRIVE_MAX_RST = 16'd40960;
  localparam logic [16:0] MIX_RST       = 17'd0;
  localparam logic [16:0] MIX_FULL      = 17'd65536;
  localparam logic [15:0] DC_COEFF_RST  = 16'd65365;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE     = 3'd0,
    CFG_DRIVE_MIN = 3'd1,
    CFG_DRIVE_MAX = 3'd2,
    CFG_MIX       = 3'd3,
    CFG_DC_COEFF  = 3'd4
  } cfg_idx_e;

  // Which tanh argument is being evaluated.
  typedef enum logic [1:0] {
    ARG_ZO,
    ARG_POS,
    ARG_NEG,
    ARG_X
  } arg_e;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BIAS,
    OP_BFIN,
    OP_ARG,
    OP_TADDR,
    OP_TROM,
    OP_TMUL,
    OP_TFIN,
    OP_CEIL,
    OP_SH,
    OP_SFIN,
    OP_DC1,
    OP_DC2,
    OP_MIX1,
    OP_MIX2,
    OP_OUT
  } op_e;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BIAS,
    ST_BDIV,
    ST_BFIN,
    ST_ARG,
    ST_TADDR,
    ST_TROM,
    ST_TMUL,
    ST_TFIN,
    ST_CEIL,
    ST_SH,
    ST_SDIV,
    ST_SFIN,
    ST_DC1,
    ST_DC2,
    ST_MIX1,
    ST_MIX2,
    ST_OUT
  } state_e;

  // Command word from controller to datapath.
  typedef struct packed {
    op_e  op;
    arg_e arg;
    logic ch;
  } cmd_t;

  // Status word from datapath to controller.
  typedef struct packed {
    logic div_busy;
    logic bias_direct;
    logic sh_direct;
    logic mix_zero;
    logic out_free;
    logic cfg_we;
  } stat_t;

endpackage

[hdl/sats_ctrl.sv]
// ---------------------------------------------------------------------------
// sats_ctrl
// Sequencer that steps the datapath through the bias set-up and the
// per-channel shaping, filtering and mixing of one stereo word.
// ---------------------------------------------------------------------------
module sats_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sats_pkg::stat_t stat_i,
  output sats_pkg::cmd_t  cmd_o
);

  sats_pkg::state_e state_q, state_d;
  sats_pkg::arg_e   arg_q, arg_d;
  logic             ch_q, ch_d;
  logic             prep_ok_q, prep_ok_d;

  // State and sequencing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sats_pkg::ST_IDLE;
      arg_q     <= sats_pkg::ARG_ZO;
      ch_q      <= 1'b0;
      prep_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      arg_q     <= arg_d;
      ch_q      <= ch_d;
      prep_ok_q <= prep_ok_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    arg_d      = arg_q;
    ch_d       = ch_q;
    prep_ok_d  = prep_ok_q;
    in_ready_o = 1'b0;
    cmd_o.op   = sats_pkg::OP_NONE;
    cmd_o.arg  = arg_q;
    cmd_o.ch   = ch_q;
    case (state_q)
      sats_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = sats_pkg::OP_LOAD;
          ch_d     = 1'b0;
          if (stat_i.mix_zero) begin
            state_d = sats_pkg::ST_OUT;
          end else if (!prep_ok_q) begin
            state_d = sats_pkg::ST_BIAS;
          end else begin
            arg_d   = sats_pkg::ARG_X;
            state_d = sats_pkg::ST_ARG;
          end
        end
      end
      sats_pkg::ST_BIAS: begin
        cmd_o.op = sats_pkg::OP_BIAS;
        state_d  = stat_i.bias_direct ? sats_pkg::ST_BFIN : sats_pkg::ST_BDIV;
      end
      sats_pkg::ST_BDIV: begin
        if (!stat_i.div_busy) begin
          state_d = sats_pkg::ST_BFIN;
        end
      end
      sats_pkg::ST_BFIN: begin
        cmd_o.op = sats_pkg::OP_BFIN;
        arg_d    = sats_pkg::ARG_ZO;
        state_d  = sats_pkg::ST_ARG;
      end
      sats_pkg::ST_ARG: begin
        cmd_o.op = sats_pkg::OP_ARG;
        state_d  = sats_pkg::ST_TADDR;
      end
      sats_pkg::ST_TADDR: begin
        cmd_o.op = sats_pkg::OP_TADDR;
        state_d  = sats_pkg::ST_TROM;
      end
      sats_pkg::ST_TROM: begin
        cmd_o.op = sats_pkg::OP_TROM;
        state_d  = sats_pkg::ST_TMUL;
      end
      sats_pkg::ST_TMUL: begin
        cmd_o.op = sats_pkg::OP_TMUL;
        state_d  = sats_pkg::ST_TFIN;
      end
      sats_pkg::ST_TFIN: begin
        cmd_o.op = sats_pkg::OP_TFIN;
        case (arg_q)
          sats_pkg::ARG_ZO: begin
            arg_d   = sats_pkg::ARG_POS;
            state_d = sats_pkg::ST_ARG;
          end
          sats_pkg::ARG_POS: begin
            arg_d   = sats_pkg::ARG_NEG;
            state_d = sats_pkg::ST_ARG;
          end
          sats_pkg::ARG_NEG: begin
            state_d = sats_pkg::ST_CEIL;
          end
          default: begin
            state_d = sats_pkg::ST_SH;
          end
        endcase
      end
      sats_pkg::ST_CEIL: begin
        cmd_o.op  = sats_pkg::OP_CEIL;
        prep_ok_d = 1'b1;
        arg_d     = sats_pkg::ARG_X;
        state_d   = sats_pkg::ST_ARG;
      end
      sats_pkg::ST_SH: begin
        cmd_o.op = sats_pkg::OP_SH;
        state_d  = stat_i.sh_direct ? sats_pkg::ST_DC1 : sats_pkg::ST_SDIV;
      end
      sats_pkg::ST_SDIV: begin
        if (!stat_i.div_busy) begin
          state_d = sats_pkg::ST_SFIN;
        end
      end
      sats_pkg::ST_SFIN: begin
        cmd_o.op = sats_pkg::OP_SFIN;
        state_d  = sats_pkg::ST_DC1;
      end
      sats_pkg::ST_DC1: begin
        cmd_o.op = sats_pkg::OP_DC1;
        state_d  = sats_pkg::ST_DC2;
      end
      sats_pkg::ST_DC2: begin
        cmd_o.op = sats_pkg::OP_DC2;
        state_d  = sats_pkg::ST_MIX1;
      end
      sats_pkg::ST_MIX1: begin
        cmd_o.op = sats_pkg::OP_MIX1;
        state_d  = sats_pkg::ST_MIX2;
      end
      sats_pkg::ST_MIX2: begin
        cmd_o.op = sats_pkg::OP_MIX2;
        if (!ch_q) begin
          ch_d    = 1'b1;
          arg_d   = sats_pkg::ARG_X;
          state_d = sats_pkg::ST_ARG;
        end else begin
          state_d = sats_pkg::ST_OUT;
        end
      end
      sats_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = sats_pkg::OP_OUT;
          state_d  = sats_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sats_pkg::ST_IDLE;
      end
    endcase
    // Any register write invalidates the cached bias and ceiling.
    if (stat_i.cfg_we) begin
      prep_ok_d = 1'b0;
    end
  end

endmodule

[hdl/sats_dp.sv]
// ---------------------------------------------------------------------------
// sats_dp
// Datapath: configuration registers, tanh table with interpolation, shared
// restoring divider, DC blocker state and wet/dry mixing.
// ---------------------------------------------------------------------------
module sats_dp #(
  parameter int SAMPLE_WIDTH     = sats_pkg::SAMPLE_WIDTH_DEF,
  parameter int TANH_TABLE_DEPTH = sats_pkg::TANH_TABLE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [sats_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sats_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        left_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        right_in_i,
  input  sats_pkg::cmd_t                        cmd_i,
  output sats_pkg::stat_t                       stat_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]        left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]        right_out_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int SHW = (SW > 22) ? SW : 22;          // shaped value width
  localparam int AW  = (SW + 5 > 27) ? SW + 5 : 27;  // tanh operand width
  localparam int PW  = AW + 17;                      // operand times drive
  localparam int ZW  = PW - 12;                      // Q24 tanh argument
  localparam int IW  = $clog2(TANH_TABLE_DEPTH + 1); // table address width
  localparam int YW  = SHW + 2;
  localparam int VW  = SHW + 4;
  localparam int CPW = SW + 17;
  localparam int MPW = SW + 19;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] INV_E   = 64'd395007542;

  localparam logic signed [AW-1:0] ONE_Q24   = AW'(1 << 24);
  localparam logic signed [VW-1:0] SAMP_MAX  = VW'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [VW-1:0] SAMP_MIN  = -VW'(64'sd1 <<< (SW - 1));
  localparam logic [32:0]          Q_ONE     = 33'd1 << 20;

  typedef logic [29:0] rom_t [TANH_TABLE_DEPTH+1];

  // Long division by shift and subtract, for building the table.
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8*i/DEPTH) in Q0.30 from a truncated Taylor series of exp.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] t, f, term, plus, minus, e;
    int          n;
    for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
      t     = (64'(i) << 28) / TANH_TABLE_DEPTH;
      f     = t & 64'hFF_FFFF;
      term  = ONE_Q30;
      plus  = ONE_Q30;
      minus = '0;
      n     = int'(t >> 24);
      for (int k = 1; k <= 13; k++) begin
        term = udiv((term * f) >> 24, 64'(k));
        if (k % 2 == 1) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
      end
      e = (plus > minus) ? plus - minus : 64'd0;
      if (e > ONE_Q30) begin
        e = ONE_Q30;
      end
      for (int k = 0; k < n; k++) begin
        e = (e * INV_E) >> 30;
      end
      rom[i] = 30'(udiv((ONE_Q30 - e) << 30, ONE_Q30 + e));
    end
    return rom;
  endfunction

  localparam rom_t TANH_ROM = build_rom();

  // Saturate a wide value to the sample range.
  function automatic logic signed [SW-1:0] sat_samp(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = v;
    if (v > SAMP_MAX) begin
      r = SAMP_MAX;
    end else if (v < SAMP_MIN) begin
      r = SAMP_MIN;
    end
    return SW'(r);
  endfunction

  // Configuration registers.
  logic [15:0] drive_q, drive_min_q, drive_max_q, dc_coeff_q;
  logic [16:0] mix_q;
  logic [15:0] drive_wr;
  logic        cfg_dc_we;

  // Payload registers.
  logic signed [SW-1:0]  left_q, right_q;
  logic [16:0]           amt_q;
  logic                  amt_div_q;
  logic [22:0]           bias_q;
  logic signed [ZW-1:0]  z_q;
  logic                  neg_q;
  logic [IW-1:0]         idx_q;
  logic [27:0]           frac_q;
  logic [29:0]           lo_q, hi_q;
  logic                  dneg_q;
  logic [57:0]           tprod_q;
  logic signed [31:0]    t_zo_q, t_pos_q, t_neg_q, t_x_q;
  logic signed [32:0]    ceil_q;
  logic                  ceil_pos_q;
  logic                  sneg_q;
  logic signed [SHW-1:0] s_q;
  logic signed [CPW-1:0] cprod_q;
  logic signed [SW-1:0]  y_q;
  logic signed [MPW-1:0] xprod_q;
  logic signed [SW-1:0]  res_q [2];
  logic signed [SHW-1:0] prev_s_q [2];
  logic signed [SW-1:0]  prev_y_q [2];
  logic signed [SW-1:0]  left_out_q, right_out_q;
  logic                  out_valid_q;

  // Divider registers.
  logic [32:0] rem_q, den_q;
  logic [19:0] quo_q;
  logic [4:0]  cnt_q;

  // Combinational intermediates.
  logic signed [SW-1:0]    x_ch;
  logic signed [AW-1:0]    bias_ext, opnd;
  logic signed [PW-1:0]    aprod;
  logic [ZW-1:0]           za;
  logic                    z_sat;
  logic [26+IW:0]          tpos;
  logic signed [30:0]      tdiff;
  logic [29:0]             tmag_d;
  logic signed [31:0]      t_mag, t_res;
  logic [16:0]             amount;
  logic [39:0]             bprod;
  logic signed [32:0]      ps, ns, sh;
  logic [32:0]             sh_abs;
  logic                    sh_ge;
  logic signed [YW-1:0]    ysum;
  logic signed [SW:0]      mdiff;
  logic signed [VW-1:0]    osum;
  logic                    bias_direct;
  logic [33:0]             rem2;

  assign x_ch = cmd_i.ch ? right_q : left_q;

  // Drive writes are raised to the minimum, then lowered to the maximum.
  always_comb begin
    drive_wr = cfg_data_i[15:0];
    if (drive_wr < drive_min_q) begin
      drive_wr = drive_min_q;
    end
    if (drive_wr > drive_max_q) begin
      drive_wr = drive_max_q;
    end
  end

  assign cfg_dc_we = cfg_valid_i &&
                     (sats_pkg::cfg_idx_e'(cfg_index_i) == sats_pkg::CFG_DC_COEFF);

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q     <= sats_pkg::DRIVE_RST;
      drive_min_q <= sats_pkg::DRIVE_MIN_RST;
      drive_max_q <= sats_pkg::DRIVE_MAX_RST;
      mix_q       <= sats_pkg::MIX_RST;
      dc_coeff_q  <= sats_pkg::DC_COEFF_RST;
    end else if (cfg_valid_i) begin
      case (sats_pkg::cfg_idx_e'(cfg_index_i))
        sats_pkg::CFG_DRIVE:     drive_q     <= drive_wr;
        sats_pkg::CFG_DRIVE_MIN: drive_min_q <= cfg_data_i[15:0];
        sats_pkg::CFG_DRIVE_MAX: drive_max_q <= cfg_data_i[15:0];
        sats_pkg::CFG_MIX: begin
          mix_q <= (cfg_data_i > sats_pkg::MIX_FULL) ? sats_pkg::MIX_FULL : cfg_data_i;
        end
        sats_pkg::CFG_DC_COEFF:  dc_coeff_q  <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Bias ramp end points bypass the divider.
  assign bias_direct = (drive_q <= drive_min_q) || (drive_q >= drive_max_q);
  assign amount      = amt_div_q ? {1'b0, quo_q[15:0]} : amt_q;
  assign bprod       = 40'd5368709 * 40'(amount);

  // Tanh operand (Q24) times drive: offset, offset +/- 1 or offset + sample.
  always_comb begin
    bias_ext = AW'(bias_q);
    case (cmd_i.arg)
      sats_pkg::ARG_ZO:  opnd = bias_ext;
      sats_pkg::ARG_POS: opnd = ONE_Q24 + bias_ext;
      sats_pkg::ARG_NEG: opnd = bias_ext - ONE_Q24;
      default:           opnd = (AW'(x_ch) <<< 4) + bias_ext;
    endcase
    aprod = PW'(opnd) * PW'(signed'({1'b0, drive_q}));
  end

  // Table address and fraction; beyond the table the last entry is taken.
  always_comb begin
    za    = z_q[ZW-1] ? ZW'(-z_q) : ZW'(z_q);
    z_sat = |za[ZW-1:27];
    tpos  = (27 + IW)'(za[26:0]) * (27 + IW)'(TANH_TABLE_DEPTH);
  end

  // Interpolation between neighbouring table entries.
  always_comb begin
    tdiff  = signed'({1'b0, hi_q}) - signed'({1'b0, lo_q});
    tmag_d = tdiff[30] ? 30'(-tdiff) : 30'(tdiff);
    t_mag  = dneg_q ? 32'(lo_q) - 32'(tprod_q >> 27) : 32'(lo_q) + 32'(tprod_q >> 27);
    t_res  = neg_q ? -t_mag : t_mag;
  end

  // Half-spans, shaped value and its comparison with the ceiling.
  always_comb begin
    ps     = 33'(t_pos_q) - 33'(t_zo_q);
    ns     = 33'(t_zo_q) - 33'(t_neg_q);
    sh     = 33'(t_x_q) - 33'(t_zo_q);
    sh_abs = sh[32] ? 33'(-sh) : 33'(sh);
    sh_ge  = sh_abs >= 33'(ceil_q);
  end

  // DC blocker sum and wet/dry difference.
  always_comb begin
    ysum  = YW'(s_q) - YW'(prev_s_q[cmd_i.ch]) + YW'(cprod_q >>> 16);
    mdiff = (SW + 1)'(y_q) - (SW + 1)'(x_ch);
    osum  = VW'(x_ch) + VW'(xprod_q >>> 16);
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sats_pkg::OP_LOAD: begin
        left_q  <= left_in_i;
        right_q <= right_in_i;
      end
      sats_pkg::OP_BIAS: begin
        amt_div_q <= !bias_direct;
        amt_q     <= (drive_q <= drive_min_q) ? 17'd0 : sats_pkg::MIX_FULL;
      end
      sats_pkg::OP_BFIN: begin
        bias_q <= 23'(40'd1342177 + (bprod >> 16));
      end
      sats_pkg::OP_ARG: begin
        z_q <= ZW'(aprod >>> 12);
      end
      sats_pkg::OP_TADDR: begin
        neg_q <= z_q[ZW-1];
        if (z_sat) begin
          idx_q  <= IW'(TANH_TABLE_DEPTH - 1);
          frac_q <= 28'h800_0000;
        end else begin
          idx_q  <= tpos[26+IW:27];
          frac_q <= {1'b0, tpos[26:0]};
        end
      end
      sats_pkg::OP_TROM: begin
        lo_q <= TANH_ROM[idx_q];
        hi_q <= TANH_ROM[idx_q + IW'(1)];
      end
      sats_pkg::OP_TMUL: begin
        dneg_q  <= tdiff[30];
        tprod_q <= 58'(tmag_d) * 58'(frac_q);
      end
      sats_pkg::OP_TFIN: begin
        case (cmd_i.arg)
          sats_pkg::ARG_ZO:  t_zo_q  <= t_res;
          sats_pkg::ARG_POS: t_pos_q <= t_res;
          sats_pkg::ARG_NEG: t_neg_q <= t_res;
          default:           t_x_q   <= t_res;
        endcase
      end
      sats_pkg::OP_CEIL: begin
        ceil_q     <= (ps > ns) ? ps : ns;
        ceil_pos_q <= ((ps > ns) ? ps : ns) > 33'sd0;
      end
      sats_pkg::OP_SH: begin
        sneg_q <= sh[32];
        if (!ceil_pos_q) begin
          s_q <= SHW'(x_ch);
        end else if (sh_ge) begin
          s_q <= sh[32] ? -SHW'(Q_ONE) : SHW'(Q_ONE);
        end
      end
      sats_pkg::OP_SFIN: begin
        s_q <= sneg_q ? -SHW'(quo_q) : SHW'(quo_q);
      end
      sats_pkg::OP_DC1: begin
        cprod_q <= CPW'(prev_y_q[cmd_i.ch]) * CPW'(signed'({1'b0, dc_coeff_q}));
      end
      sats_pkg::OP_DC2: begin
        y_q <= sat_samp(VW'(ysum));
      end
      sats_pkg::OP_MIX1: begin
        xprod_q <= MPW'(mdiff) * MPW'(signed'({1'b0, mix_q}));
      end
      sats_pkg::OP_MIX2: begin
        res_q[cmd_i.ch] <= sat_samp(osum);
      end
      sats_pkg::OP_OUT: begin
        left_out_q  <= (mix_q == '0) ? left_q : res_q[0];
        right_out_q <= (mix_q == '0) ? right_q : res_q[1];
      end
      default: begin
      end
    endcase
  end

  // Filter history: cleared by a coefficient write, else updated per channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_s_q[0] <= '0;
      prev_s_q[1] <= '0;
      prev_y_q[0] <= '0;
      prev_y_q[1] <= '0;
    end else if (cfg_dc_we) begin
      prev_s_q[0] <= '0;
      prev_s_q[1] <= '0;
      prev_y_q[0] <= '0;
      prev_y_q[1] <= '0;
    end else if (cmd_i.op == sats_pkg::OP_DC2) begin
      prev_s_q[cmd_i.ch] <= s_q;
      prev_y_q[cmd_i.ch] <= sat_samp(VW'(ysum));
    end
  end

  // Restoring divider: floor(rem * 2^K / den) for rem below den.
  assign rem2 = {rem_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.op == sats_pkg::OP_BIAS && !bias_direct) begin
      cnt_q <= 5'd16;
    end else if (cmd_i.op == sats_pkg::OP_SH && ceil_pos_q && !sh_ge) begin
      cnt_q <= 5'd20;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sats_pkg::OP_BIAS) begin
      rem_q <= 33'(drive_q - drive_min_q);
      den_q <= 33'(drive_max_q - drive_min_q);
      quo_q <= '0;
    end else if (cmd_i.op == sats_pkg::OP_SH) begin
      rem_q <= sh_abs;
      den_q <= 33'(ceil_q);
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      if (rem2 >= {1'b0, den_q}) begin
        rem_q <= 33'(rem2 - {1'b0, den_q});
        quo_q <= {quo_q[18:0], 1'b1};
      end else begin
        rem_q <= rem2[32:0];
        quo_q <= {quo_q[18:0], 1'b0};
      end
    end
  end

  // Output register, released by the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == sats_pkg::OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

  // Status towards the controller.
  always_comb begin
    stat_o.div_busy    = cnt_q != '0;
    stat_o.bias_direct = bias_direct;
    stat_o.sh_direct   = !ceil_pos_q || sh_ge;
    stat_o.mix_zero    = mix_q == '0;
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.cfg_we      = cfg_valid_i;
  end

endmodule

[hdl/stereo_asymmetric_tanh_saturator.sv]
// ---------------------------------------------------------------------------
// stereo_asymmetric_tanh_saturator
// Asymmetric tanh soft clipper with DC blocker and wet/dry mix, stereo.
// ---------------------------------------------------------------------------
// Usage:
// A stereo word (left_in_i, right_in_i, Q4.20) is taken when in_valid_i and
// in_ready_o are both high; one word (left_out_o, right_out_o) is returned
// on out_valid_o/out_ready_i for every word taken. One word is processed at
// a time: in_ready_o is high only while the sequencer is idle.
// With mix at zero a word skips the shaper and goes straight to the output
// register. Otherwise each channel skips the divider when the shaped value
// reaches the ceiling or the ceiling is not positive, and else waits for
// the 20-step shared divider. After reset or any register write the first
// word also recomputes bias, zero offset and ceiling (a 16-step divide and
// three table lookups); at either end of the bias ramp the divide is skipped.
// The register port (cfg_valid_i, cfg_index_i, cfg_data_i) is always ready;
// writes are to be made by the user only while the block is idle, and the
// block itself does not enforce this. A dc_coeff write clears the filter
// history. Reset loads the default registers and clears the history.
// A stalled receiver holds the output register; the next word may be taken
// and processed meanwhile, and its result waits until the register frees.
// ---------------------------------------------------------------------------
`include "stereo_asymmetric_tanh_saturator_defines.svh"

module stereo_asymmetric_tanh_saturator #(
  parameter int SAMPLE_WIDTH     = sats_pkg::SAMPLE_WIDTH_DEF,
  parameter int TANH_TABLE_DEPTH = sats_pkg::TANH_TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sats_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sats_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    left_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    right_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]    left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]    right_out_o
);

  sats_pkg::cmd_t  ctrl_cmd;
  sats_pkg::stat_t dp_stat;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  sats_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // Arithmetic and storage.
  sats_dp #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  // The output register is only loaded once the previous word has gone.
  `SATS_ASSERT_IMP(a_out_load_free, ctrl_cmd.op == sats_pkg::OP_OUT, !out_valid_o || out_ready_i)
  // A word taken closes the input until its processing is complete.
  `SATS_ASSERT_NXT(a_one_word, in_valid_i && in_ready_o, !in_ready_o)
  // The divider is quiet whenever the sequencer is idle.
  `SATS_ASSERT_IMP(a_idle_div_quiet, in_ready_o, !dp_stat.div_busy)

endmodule

[verif/tb_stereo_asymmetric_tanh_saturator.sv]
// ---------------------------------------------------------------------------
// tb_stereo_asymmetric_tanh_saturator
// Self-checking bench for the stereo tanh soft clipper with DC blocker.
// A scoreboard class predicts every output word from its own copy of the
// registers, the tanh table and the filter history, and compares it with
// the block's output. Directed words cover the sample extremes, bypass, a
// non-positive ceiling, a degenerate drive range, mix above one, unknown
// register indexes and coefficient writes. Random phases then reprogram
// the registers and stream random words, with idle bursts on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

// Scoreboard: predicts each output word and checks the block against it.
class sats_scoreboard;
  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } word_t;

  longint unsigned tanh_rom[0:256];
  longint drive_q, drive_lo, drive_hi, mix_q, dc_q;
  longint prev_shaped[2];
  longint prev_blocked[2];
  word_t  expected_q[$];
  int     errors;
  int     words_checked;

  function new();
    longint unsigned t, f, term, plus, minus, e, n;
    for (int i = 0; i <= 256; i++) begin
      t     = (longint'(i) << 28) / 256;
      f     = t & 64'hFF_FFFF;
      n     = t >> 24;
      term  = 64'd1 << 30;
      plus  = 64'd1 << 30;
      minus = 0;
      // Truncated Taylor series of exp(-frac), then whole powers of 1/e.
      for (int k = 1; k <= 13; k++) begin
        term = ((term * f) >> 24) / k;
        if (k % 2 == 1) minus += term;
        else plus += term;
      end
      e = (plus > minus) ? plus - minus : 0;
      if (e > (64'd1 << 30)) e = 64'd1 << 30;
      for (longint unsigned k = 0; k < n; k++) e = (e * 64'd395007542) >> 30;
      tanh_rom[i] = (((64'd1 << 30) - e) << 30) / ((64'd1 << 30) + e);
    end
    drive_q  = 4096;
    drive_lo = 4096;
    drive_hi = 40960;
    mix_q    = 0;
    dc_q     = 65365;
    clear_history();
    errors        = 0;
    words_checked = 0;
  endfunction

  function void clear_history();
    for (int c = 0; c < 2; c++) begin
      prev_shaped[c]  = 0;
      prev_blocked[c] = 0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [16:0] data);
    longint v;
    v = data & 17'hFFFF;
    case (idx)
      sats_pkg::CFG_DRIVE: begin
        if (v < drive_lo) v = drive_lo;
        if (v > drive_hi) v = drive_hi;
        drive_q = v;
      end
      sats_pkg::CFG_DRIVE_MIN: drive_lo = v;
      sats_pkg::CFG_DRIVE_MAX: drive_hi = v;
      sats_pkg::CFG_MIX: mix_q = (data > 17'd65536) ? 65536 : longint'(data);
      sats_pkg::CFG_DC_COEFF: begin
        dc_q = v;
        clear_history();
      end
      default: ;
    endcase
  endfunction

  // Interpolated tanh in Q2.30 of a Q24 argument, odd symmetric.
  function longint tanh_q30(longint z);
    longint a, r, lo, d, frac;
    longint unsigned pos, idx;
    a = (z < 0) ? -z : z;
    if (a >= (longint'(8) << 24)) begin
      r = tanh_rom[256];
    end else begin
      pos  = a * 256;
      idx  = pos >> 27;
      frac = pos & ((64'd1 << 27) - 1);
      if (idx >= 256) idx = 255;
      lo = tanh_rom[idx];
      d  = longint'(tanh_rom[idx + 1]) - lo;
      if (d >= 0) r = lo + ((d * frac) >>> 27);
      else r = lo - (((-d) * frac) >>> 27);
    end
    return (z < 0) ? -r : r;
  endfunction

  function longint bias_q24();
    longint amount;
    if (drive_q <= drive_lo) amount = 0;
    else if (drive_q >= drive_hi) amount = 65536;
    else amount = ((drive_q - drive_lo) << 16) / (drive_hi - drive_lo);
    return 1342177 + ((longint'(5368709) * amount) >>> 16);
  endfunction

  function longint shape_sample(longint x);
    longint b, zo, ps, ns, ceiling, sh, q;
    b       = bias_q24();
    zo      = tanh_q30((b * drive_q) >>> 12);
    ps      = tanh_q30((((longint'(1) << 24) + b) * drive_q) >>> 12) - zo;
    ns      = zo - tanh_q30(((b - (longint'(1) << 24)) * drive_q) >>> 12);
    ceiling = (ps > ns) ? ps : ns;
    if (ceiling <= 0) return x;
    sh = tanh_q30(((x * 16 + b) * drive_q) >>> 12) - zo;
    q  = (sh * (longint'(1) << 20)) / ceiling;
    if (q > (longint'(1) << 20)) q = longint'(1) << 20;
    if (q < -(longint'(1) << 20)) q = -(longint'(1) << 20);
    return q;
  endfunction

  function longint clip_sample(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function logic signed [23:0] process_channel(logic signed [23:0] dry, int c);
    longint x, s, y;
    x = dry;
    if (mix_q == 0) return dry;
    s = shape_sample(x);
    y = clip_sample(s - prev_shaped[c] + ((dc_q * prev_blocked[c]) >>> 16));
    prev_shaped[c]  = s;
    prev_blocked[c] = y;
    return 24'(clip_sample(x + (((y - x) * mix_q) >>> 16)));
  endfunction

  function void note_word(logic signed [23:0] l, logic signed [23:0] r);
    word_t w;
    w.left  = process_channel(l, 0);
    w.right = process_channel(r, 1);
    expected_q.push_back(w);
  endfunction

  function void check_word(logic signed [23:0] l, logic signed [23:0] r);
    word_t w;
    if (expected_q.size() == 0) begin
      $display("%0t: output word %0d/%0d arrived with none expected", $time, l, r);
      errors++;
      return;
    end
    w = expected_q.pop_front();
    words_checked++;
    if (w.left !== l) begin
      $display("%0t: left_out expected %0d actual %0d", $time, w.left, l);
      errors++;
    end
    if (w.right !== r) begin
      $display("%0t: right_out expected %0d actual %0d", $time, w.right, r);
      errors++;
    end
  endfunction
endclass

module tb_stereo_asymmetric_tanh_saturator;

  localparam int IDLE_LIMIT = 4000;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [sats_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [sats_pkg::CFG_DATA_W-1:0]    cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [23:0]                 left_in;
  logic signed [23:0]                 right_in;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [23:0]                 left_out;
  logic signed [23:0]                 right_out;

  sats_scoreboard sb = new();
  bit  idling_on = 1'b1;
  int  stall_left = 0;
  int  idle_cycles = 0;
  int  words_sent = 0;
  int  writes_done = 0;

  stereo_asymmetric_tanh_saturator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .left_in_i   (left_in),
    .right_in_i  (right_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .left_out_o  (left_out),
    .right_out_o (right_out)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitors: note accepted input words and check accepted output words.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_word(left_in, right_in);
    if (rst_n && out_valid && out_ready) sb.check_word(left_out, right_out);
  end

  // Watchdog on cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver with random stall bursts.
  always @(negedge clk) begin
    if (!idling_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Drive one stereo word; called at a falling edge, returns at one.
  task automatic send_word(logic signed [23:0] l, logic signed [23:0] r);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Let all outstanding words drain, then write one register.
  task automatic write_reg(logic [sats_pkg::CFG_IDX_W-1:0] idx,
                           logic [sats_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    writes_done++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random sample: full range, the useful span near unity, extremes or tiny.
  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed(24'($urandom_range(0, 3 << 20))) - (3 << 19));
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'($signed(24'($urandom_range(0, 64))) - 32);
    endcase
  endfunction

  function automatic logic [15:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus.
  initial begin
    logic [16:0] mix;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    left_in   = '0;
    right_in  = '0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Bypass with reset registers: the output equals the input.
    send_word(24'sh7FFFFF, 24'sh800000);
    send_word(24'sd0, -24'sd1);
    // Fully wet with reset drive.
    write_reg(sats_pkg::CFG_MIX, sats_pkg::MIX_FULL);
    send_word(24'sh7FFFFF, 24'sh800000);
    send_word(24'sd0, 24'sd1);
    send_word(24'sh100000, -24'sh100000);
    send_word(-24'sd1, 24'sh0FFFFF);
    // Drive at zero leaves no ceiling, so the shaper passes the input.
    write_reg(sats_pkg::CFG_DRIVE_MIN, 17'd0);
    write_reg(sats_pkg::CFG_DRIVE, 17'd0);
    write_reg(sats_pkg::CFG_MIX, 17'd40000);
    send_word(24'sh7FFFFF, 24'sh800000);
    send_word(24'sh123456, -24'sh054321);
    // Minimum above maximum: the drive write is lowered to the maximum.
    write_reg(sats_pkg::CFG_DRIVE_MIN, 17'd50000);
    write_reg(sats_pkg::CFG_DRIVE_MAX, 17'd1000);
    write_reg(sats_pkg::CFG_DRIVE, 17'd30000);
    send_word(24'sh080000, -24'sh080000);
    // Mix above one is held at one; unknown indexes are ignored.
    write_reg(sats_pkg::CFG_MIX, 17'h1FFFF);
    write_reg(3'd5, 17'h1FFFF);
    write_reg(3'd7, 17'h00000);
    send_word(24'sh7FFFFF, 24'sh800000);
    // Drive and coefficient extremes; coefficient writes clear the history.
    write_reg(sats_pkg::CFG_DRIVE_MIN, 17'd0);
    write_reg(sats_pkg::CFG_DRIVE_MAX, 17'hFFFF);
    write_reg(sats_pkg::CFG_DRIVE, 17'hFFFF);
    write_reg(sats_pkg::CFG_DC_COEFF, 17'd0);
    send_word(24'sh7FFFFF, 24'sh800000);
    send_word(24'sh800000, 24'sh7FFFFF);
    write_reg(sats_pkg::CFG_DC_COEFF, 17'hFFFF);
    send_word(24'sh7FFFFF, 24'sh800000);
    send_word(24'sh7FFFFF, 24'sh800000);
    send_word(24'sd0, 24'sd0);

    // Random phases; the last one runs with no idling.
    for (int p = 0; p < 14; p++) begin
      if (p == 13) idling_on = 1'b0;
      if ($urandom_range(0, 1)) write_reg(sats_pkg::CFG_DRIVE_MIN, 17'(rand_q16()));
      if ($urandom_range(0, 1)) write_reg(sats_pkg::CFG_DRIVE_MAX, 17'(rand_q16()));
      write_reg(sats_pkg::CFG_DRIVE,
                17'($urandom_range(0, 3) == 0 ? rand_q16() : $urandom));
      case ($urandom_range(0, 5))
        0: mix = 17'd0;
        1: mix = sats_pkg::MIX_FULL;
        2: mix = 17'($urandom_range(65537, 131071));
        default: mix = 17'($urandom_range(1, 65535));
      endcase
      write_reg(sats_pkg::CFG_MIX, mix);
      if ($urandom_range(0, 1)) write_reg(sats_pkg::CFG_DC_COEFF, 17'(rand_q16()));
      for (int i = 0; i < 128; i++) send_word(rand_sample(), rand_sample());
    end
    in_valid <= 1'b0;

    // Drain and let the block settle.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d stereo words and %0d register writes; %0d output words checked.",
             words_sent, writes_done, sb.words_checked);
    $display("Covered bypass, zero ceiling, inverted drive range, mix clamp and filter clears.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d words outstanding", sb.errors, sb.expected_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/sats_pkg.sv
hdl/sats_ctrl.sv
hdl/sats_dp.sv
hdl/stereo_asymmetric_tanh_saturator.sv
verif/tb_stereo_asymmetric_tanh_saturator.sv
